FILE: rtl/fdes_pkg.sv
// ----------------------------------------------------------------------------
// fdes_pkg: shared types and constants for the FAT directory entry scan
// Status codes, register indexes, pipeline structs and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fdes_pkg;

   localparam int NAME_CHARS      = 12;
   localparam int BASE_CHARS      = 8;
   localparam int EXT_CHARS       = 3;
   localparam int RAW_CHARS       = BASE_CHARS + EXT_CHARS;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [7:0] CHAR_END     = 8'h00;
   localparam logic [7:0] CHAR_KANJI   = 8'h05;
   localparam logic [7:0] CHAR_FREE    = 8'hE5;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [7:0] ATTR_VOLUME_ID = 8'h08;
   localparam logic [3:0] ATTR_LONG_NAME = 4'hF;

   typedef enum logic [2:0] {
      STATUS_SKIPPED  = 3'd0,
      STATUS_LIVE     = 3'd1,
      STATUS_FOUND    = 3'd2,
      STATUS_END      = 3'd3,
      STATUS_FINISHED = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE               = 3'd0,
      CSR_TARGET_INDEX       = 3'd1,
      CSR_TARGET_NAME_LOW    = 3'd2,
      CSR_TARGET_NAME_HIGH   = 3'd3,
      CSR_TARGET_NAME_LENGTH = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] target_index;
      logic [63:0] target_name_low;
      logic [31:0] target_name_high;
      logic [3:0]  target_name_length;
   } cfg_type;

   // per-byte lane findings
   typedef struct packed {
      logic [7:0] dchar;
      logic       illegal;
      logic       space;
   } lane_type;

   // classified entry, between the front stage and the select stage
   typedef struct packed {
      logic        valid;
      logic        first_of_scan;
      logic        end_dir;
      logic        skip;
      logic        name_match;
      logic [31:0] entry_number;
      logic [63:0] decoded_low;
      logic [31:0] decoded_high;
      logic [3:0]  decoded_length;
   } s1_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] entry_number;
      logic [63:0] decoded_low;
      logic [31:0] decoded_high;
      logic [3:0]  decoded_length;
   } rsp_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/fdes_req_if.sv
// ----------------------------------------------------------------------------
// fdes_req_if: directory entry input channel
// Valid/ready channel carrying one raw 32-byte entry's relevant fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdes_req_if;
   logic        valid;
   logic        ready;
   logic        first_of_scan;
   logic [63:0] name_base;
   logic [23:0] name_extension;
   logic [7:0]  attributes;
   logic [47:0] sector_address;
   logic [3:0]  slot;

   modport source (output valid, first_of_scan, name_base, name_extension, attributes,
                   sector_address, slot, input ready);
   modport sink (input valid, first_of_scan, name_base, name_extension, attributes,
                 sector_address, slot, output ready);
endinterface

`default_nettype wire

FILE: rtl/fdes_rsp_if.sv
// ----------------------------------------------------------------------------
// fdes_rsp_if: classification result channel
// Valid/ready channel carrying status, entry number and decoded 8.3 name.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdes_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] entry_number;
   logic [63:0] decoded_low;
   logic [31:0] decoded_high;
   logic [3:0]  decoded_length;

   modport source (output valid, status, entry_number, decoded_low, decoded_high,
                   decoded_length, input ready);
   modport sink (input valid, status, entry_number, decoded_low, decoded_high,
                 decoded_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/fdes_csr_if.sv
// ----------------------------------------------------------------------------
// fdes_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdes_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fdes_lane.sv
// ----------------------------------------------------------------------------
// fdes_lane: per-byte name character check
// Flags illegal short-name bytes and spaces, maps a leading 0x05 to 0xE5.
// ----------------------------------------------------------------------------
`default_nettype none

module fdes_lane #(
   parameter bit LEAD = 1'b0
) (
   input  wire logic [7:0]       byte_in,
   output fdes_pkg::lane_type    lane_out
);

   logic [7:0] c;

   always_comb begin
      c = byte_in;
      if (LEAD && byte_in == fdes_pkg::CHAR_KANJI) begin
         c = fdes_pkg::CHAR_FREE;
      end
      lane_out.dchar   = c;
      lane_out.space   = (byte_in == fdes_pkg::CHAR_SPACE);
      // control codes and " * + , . / : ; < = > ? [ \ ] |
      lane_out.illegal = (c < fdes_pkg::CHAR_SPACE) ||
                         (c inside {8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F,
                                    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
                                    8'h5B, 8'h5C, 8'h5D, 8'h7C});
   end

endmodule

`default_nettype wire

FILE: rtl/fdes_classify.sv
// ----------------------------------------------------------------------------
// fdes_classify: front stage, byte lanes and merge
// Eleven byte lanes feed a merge that trims, decodes and matches the name;
// the result is registered for the select stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fdes_classify #(
   parameter int ENTRIES_PER_SECTOR = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   fdes_req_if.sink               req,
   input  wire fdes_pkg::cfg_type cfg,
   input  wire logic              take,
   output fdes_pkg::s1_type       s1
);

   localparam logic [31:0] EPS = 32'(ENTRIES_PER_SECTOR);

   fdes_pkg::lane_type lanes [fdes_pkg::RAW_CHARS];
   logic [7:0]  raw [fdes_pkg::RAW_CHARS];
   logic [7:0]  dec [fdes_pkg::NAME_CHARS];
   logic [7:0]  want [fdes_pkg::NAME_CHARS];
   logic [3:0]  stem_len;
   logic [1:0]  ext_len;
   logic [3:0]  name_len;
   logic        any_illegal;
   logic        skip;
   logic        match;
   logic [63:0] dec_low;
   logic [31:0] dec_high;
   logic [31:0] entry_number;
   logic        load;

   fdes_pkg::s1_type s1_ff, s1_in;
   logic             valid_ff, valid_in;

   genvar g;
   generate
      for (g = 0; g < fdes_pkg::RAW_CHARS; g++) begin : g_lane
         if (g < fdes_pkg::BASE_CHARS) begin : g_base
            assign raw[g] = req.name_base[8*g +: 8];
         end else begin : g_ext
            assign raw[g] = req.name_extension[8*(g-fdes_pkg::BASE_CHARS) +: 8];
         end
         fdes_lane #(.LEAD(g == 0)) u_lane (
            .byte_in  (raw[g]),
            .lane_out (lanes[g])
         );
      end
   endgenerate

   always_comb begin
      stem_len = '0;
      for (int i = 0; i < fdes_pkg::BASE_CHARS; i++) begin
         if (!lanes[i].space) stem_len = 4'(i + 1);
      end
      ext_len = '0;
      for (int i = 0; i < fdes_pkg::EXT_CHARS; i++) begin
         if (!lanes[fdes_pkg::BASE_CHARS + i].space) ext_len = 2'(i + 1);
      end
      name_len = (ext_len != 2'd0) ? 4'(stem_len + 4'd1 + 4'(ext_len)) : stem_len;

      any_illegal = 1'b0;
      for (int i = 0; i < fdes_pkg::RAW_CHARS; i++) begin
         any_illegal = any_illegal | lanes[i].illegal;
      end
      skip = (raw[0] == fdes_pkg::CHAR_FREE) ||
             (req.attributes[3:0] == fdes_pkg::ATTR_LONG_NAME) ||
             ((req.attributes & fdes_pkg::ATTR_VOLUME_ID) != 8'h00) ||
             (raw[0] != fdes_pkg::CHAR_DOT && any_illegal);

      // base characters first, then the dot and extension right after them
      for (int p = 0; p < fdes_pkg::NAME_CHARS; p++) begin
         dec[p] = 8'h00;
      end
      for (int p = 0; p < fdes_pkg::BASE_CHARS; p++) begin
         if (4'(p) < stem_len) dec[p] = lanes[p].dchar;
      end
      for (int p = 0; p < fdes_pkg::NAME_CHARS; p++) begin
         if (ext_len != 2'd0 && 4'(p) == stem_len) dec[p] = fdes_pkg::CHAR_DOT;
         for (int j = 0; j < fdes_pkg::EXT_CHARS; j++) begin
            if (2'(j) < ext_len && 5'(p) == 5'(stem_len) + 5'(j + 1)) begin
               dec[p] = raw[fdes_pkg::BASE_CHARS + j];
            end
         end
      end

      for (int p = 0; p < fdes_pkg::BASE_CHARS; p++) begin
         want[p] = cfg.target_name_low[8*p +: 8];
      end
      for (int p = 0; p < fdes_pkg::NAME_CHARS - fdes_pkg::BASE_CHARS; p++) begin
         want[fdes_pkg::BASE_CHARS + p] = cfg.target_name_high[8*p +: 8];
      end
      match = (cfg.target_name_length == name_len);
      for (int p = 0; p < fdes_pkg::NAME_CHARS; p++) begin
         if (4'(p) < name_len &&
             fdes_pkg::fold_case(dec[p]) != fdes_pkg::fold_case(want[p])) begin
            match = 1'b0;
         end
      end

      for (int p = 0; p < fdes_pkg::BASE_CHARS; p++) begin
         dec_low[8*p +: 8] = dec[p];
      end
      for (int p = 0; p < fdes_pkg::NAME_CHARS - fdes_pkg::BASE_CHARS; p++) begin
         dec_high[8*p +: 8] = dec[fdes_pkg::BASE_CHARS + p];
      end

      // only the low 32 bits of the sector reach the result
      entry_number = 32'(req.sector_address[31:0] * EPS) + 32'(req.slot);
   end

   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      s1_in                = s1_ff;
      valid_in             = valid_ff;
      if (take) valid_in   = 1'b0;
      if (load) begin
         valid_in              = 1'b1;
         s1_in.valid           = 1'b1;
         s1_in.first_of_scan   = req.first_of_scan;
         s1_in.end_dir         = (raw[0] == fdes_pkg::CHAR_END);
         s1_in.skip            = skip;
         s1_in.name_match      = match;
         s1_in.entry_number    = entry_number;
         s1_in.decoded_low     = dec_low;
         s1_in.decoded_high    = dec_high;
         s1_in.decoded_length  = name_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   always_comb begin
      s1       = s1_ff;
      s1.valid = valid_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/fdes_select.sv
// ----------------------------------------------------------------------------
// fdes_select: scan state and result register
// Applies live count and finished flag to each classified entry, picks the
// wanted entry and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fdes_select #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fdes_pkg::s1_type  s1,
   input  wire fdes_pkg::cfg_type cfg,
   output logic                   take,
   fdes_rsp_if.source             rsp
);

   logic [COUNT_WIDTH-1:0] live_count_ff, live_count_in;
   logic                   finished_ff, finished_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fdes_pkg::rsp_type      rsp_ff, rsp_in;

   logic [COUNT_WIDTH-1:0] count_eff;
   logic                   finished_eff;
   logic                   chosen;

   assign take = s1.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      count_eff    = s1.first_of_scan ? '0 : live_count_ff;
      finished_eff = s1.first_of_scan ? 1'b0 : finished_ff;
      chosen       = cfg.mode ? (33'(count_eff) == 33'(cfg.target_index)) : s1.name_match;

      live_count_in = live_count_ff;
      finished_in   = finished_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;

      if (take) begin
         rsp_valid_in          = 1'b1;
         rsp_in.entry_number   = s1.entry_number;
         rsp_in.decoded_low    = '0;
         rsp_in.decoded_high   = '0;
         rsp_in.decoded_length = '0;
         live_count_in         = count_eff;
         finished_in           = finished_eff;
         if (finished_eff) begin
            rsp_in.status       = fdes_pkg::STATUS_FINISHED;
            rsp_in.entry_number = '0;
         end else if (s1.end_dir) begin
            rsp_in.status = fdes_pkg::STATUS_END;
            finished_in   = 1'b1;
         end else if (s1.skip) begin
            rsp_in.status = fdes_pkg::STATUS_SKIPPED;
         end else begin
            rsp_in.status         = chosen ? fdes_pkg::STATUS_FOUND : fdes_pkg::STATUS_LIVE;
            rsp_in.decoded_low    = s1.decoded_low;
            rsp_in.decoded_high   = s1.decoded_high;
            rsp_in.decoded_length = s1.decoded_length;
            finished_in           = chosen;
            live_count_in         = COUNT_WIDTH'(count_eff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_count_ff <= '0;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         live_count_ff <= live_count_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_ff.status;
   assign rsp.entry_number   = rsp_ff.entry_number;
   assign rsp.decoded_low    = rsp_ff.decoded_low;
   assign rsp.decoded_high   = rsp_ff.decoded_high;
   assign rsp.decoded_length = rsp_ff.decoded_length;

endmodule

`default_nettype wire

FILE: rtl/fat_directory_entry_scan.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_scan: FAT 8.3 directory entry classifier
// Classifies one directory entry per transaction, decodes live 8.3 names and
// reports the entry chosen by name lookup or by live index.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  req_ch   in   first_of_scan, name_base, name_extension, attributes,
//                sector_address, slot
//  rsp_ch   out  status, entry_number, decoded_low, decoded_high, decoded_length
//  csr_ch   in   index, data (register write, always ready)
//
//  One transaction per cycle while the output is not stalled.
//  Byte lanes and name merge fill the front register; the select stage
//  updates live count / finished flag and loads the output register.
//  Reset clears both valid bits, the scan state and the config register.
//  A stalled output holds the front stage, which then drops req_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_directory_entry_scan #(
   parameter int ENTRIES_PER_SECTOR = 16,
   parameter int COUNT_WIDTH        = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fdes_req_if.sink   req_ch,
   fdes_rsp_if.source rsp_ch,
   fdes_csr_if.sink   csr_ch
);

   fdes_pkg::cfg_type cfg_ff, cfg_in;
   fdes_pkg::s1_type  s1;
   logic              take;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            fdes_pkg::CSR_MODE:               cfg_in.mode = csr_ch.data[0];
            fdes_pkg::CSR_TARGET_INDEX:       cfg_in.target_index = csr_ch.data[15:0];
            fdes_pkg::CSR_TARGET_NAME_LOW:    cfg_in.target_name_low = csr_ch.data;
            fdes_pkg::CSR_TARGET_NAME_HIGH:   cfg_in.target_name_high = csr_ch.data[31:0];
            fdes_pkg::CSR_TARGET_NAME_LENGTH: cfg_in.target_name_length = csr_ch.data[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fdes_classify #(
      .ENTRIES_PER_SECTOR (ENTRIES_PER_SECTOR)
   ) u_classify (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .cfg   (cfg_ff),
      .take  (take),
      .s1    (s1)
   );

   fdes_select #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_select (
      .clock (clock),
      .reset (reset),
      .s1    (s1),
      .cfg   (cfg_ff),
      .take  (take),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire
